// ===== rtl/cdd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared widths, limits, codes and calendar helpers of the day-difference core.
// ----------------------------------------------------------------------------
`default_nettype none

package cdd_pkg;

	localparam int YEAR_BITS_DEF = 14;
	localparam int DAY_W         = 5;
	localparam int MON_W         = 4;
	localparam int DIFF_W        = 23;

	// Stop stepping once the count passes the most negative result.
	localparam logic [DIFF_W-1:0] STEP_LIMIT = DIFF_W'(4194305);
	localparam logic [DIFF_W-1:0] SAT_CODE   = DIFF_W'(23'h400000);

	localparam int LEAP_CYCLE = 400;
	localparam int CENTURY    = 100;

	localparam logic [DAY_W-1:0] LAST_DAY_DEC = DAY_W'(31);
	localparam logic [MON_W-1:0] DECEMBER     = MON_W'(12);
	localparam logic [MON_W-1:0] FEBRUARY     = MON_W'(2);

	localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Operation codes from the sequencer to the date unit.
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_PREP,
		OP_STEP
	} cdd_op_t;

	// Status returned by the date unit.
	typedef struct packed {
		logic prep_done;
		logic earlier;
		logic underflow;
	} cdd_status_t;

	// Length of a month, zero for codes outside January..December.
	function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] len;
		len = '0;
		if (month == FEBRUARY) begin
			len = leap ? DAY_W'(29) : DAY_W'(28);
		end else if (month >= MON_W'(1) && month <= DECEMBER) begin
			len = MONTH_LEN[month];
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cdd_req_if.sv =====
// ----------------------------------------------------------------------------
// cdd_req_if
// Request channel: two dates and the include-end flag, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdd_req_if #(
	parameter int YEAR_BITS = cdd_pkg::YEAR_BITS_DEF
) ();
	import cdd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [DAY_W-1:0]     first_day;
	logic [MON_W-1:0]     first_month;
	logic [YEAR_BITS-1:0] first_year;
	logic [DAY_W-1:0]     second_day;
	logic [MON_W-1:0]     second_month;
	logic [YEAR_BITS-1:0] second_year;
	logic                 include_end_day;

	modport source (
		output valid, first_day, first_month, first_year,
		       second_day, second_month, second_year, include_end_day,
		input  ready
	);

	modport sink (
		input  valid, first_day, first_month, first_year,
		       second_day, second_month, second_year, include_end_day,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/cdd_res_if.sv =====
// ----------------------------------------------------------------------------
// cdd_res_if
// Result channel: signed day difference, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdd_res_if ();
	import cdd_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DIFF_W-1:0] day_difference;

	modport source (
		output valid, day_difference,
		input  ready
	);

	modport sink (
		input  valid, day_difference,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/cdd_date_unit.sv =====
// ----------------------------------------------------------------------------
// cdd_date_unit
// Working date registers with one shared decrement/compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cdd_date_unit #(
	parameter int YEAR_BITS = cdd_pkg::YEAR_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cdd_pkg::cdd_op_t             op,
	input  wire logic [cdd_pkg::DAY_W-1:0]    first_day,
	input  wire logic [cdd_pkg::MON_W-1:0]    first_month,
	input  wire logic [YEAR_BITS-1:0]         first_year,
	input  wire logic [cdd_pkg::DAY_W-1:0]    second_day,
	input  wire logic [cdd_pkg::MON_W-1:0]    second_month,
	input  wire logic [YEAR_BITS-1:0]         second_year,
	output cdd_pkg::cdd_status_t              status
);
	import cdd_pkg::*;

	localparam logic [YEAR_BITS-1:0] CYCLE_Y = YEAR_BITS'(LEAP_CYCLE);
	localparam logic [YEAR_BITS-1:0] C1_Y    = YEAR_BITS'(CENTURY);
	localparam logic [YEAR_BITS-1:0] C2_Y    = YEAR_BITS'(2 * CENTURY);
	localparam logic [YEAR_BITS-1:0] C3_Y    = YEAR_BITS'(3 * CENTURY);
	localparam logic [YEAR_BITS-1:0] CYCLE_LAST = YEAR_BITS'(LEAP_CYCLE - 1);

	logic [DAY_W-1:0]     day_q, day_d;
	logic [MON_W-1:0]     mon_q, mon_d;
	logic [YEAR_BITS-1:0] year_q, year_d;
	logic [YEAR_BITS-1:0] yr400_q, yr400_d;  // year mod 400 once prep is done
	logic [DAY_W-1:0]     sday_q;
	logic [MON_W-1:0]     smon_q;
	logic [YEAR_BITS-1:0] syear_q;
	logic                 underflow_q, underflow_d;
	logic                 leap;

	// Year mod 400 gives both the mod-4 and the century test.
	assign leap = (yr400_q[1:0] == 2'b00) && (yr400_q != C1_Y) &&
		(yr400_q != C2_Y) && (yr400_q != C3_Y);

	always_comb begin
		day_d       = day_q;
		mon_d       = mon_q;
		year_d      = year_q;
		yr400_d     = yr400_q;
		underflow_d = underflow_q;
		case (op)
			OP_LOAD: begin
				day_d       = first_day;
				mon_d       = first_month;
				year_d      = first_year;
				yr400_d     = first_year;
				underflow_d = 1'b0;
			end
			OP_PREP: begin
				yr400_d = yr400_q - CYCLE_Y;
			end
			OP_STEP: begin
				if (day_q > DAY_W'(1)) begin
					day_d = day_q - DAY_W'(1);
				end else if (mon_q > MON_W'(1)) begin
					day_d = days_in(mon_q - MON_W'(1), leap);
					mon_d = mon_q - MON_W'(1);
				end else begin
					day_d = LAST_DAY_DEC;
					mon_d = DECEMBER;
					if (year_q == '0) begin
						underflow_d = 1'b1;
						year_d      = '1;
					end else begin
						year_d  = year_q - YEAR_BITS'(1);
						yr400_d = (yr400_q == '0) ? CYCLE_LAST : yr400_q - YEAR_BITS'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q       <= '0;
			mon_q       <= '0;
			year_q      <= '0;
			yr400_q     <= '0;
			sday_q      <= '0;
			smon_q      <= '0;
			syear_q     <= '0;
			underflow_q <= 1'b0;
		end else begin
			day_q       <= day_d;
			mon_q       <= mon_d;
			year_q      <= year_d;
			yr400_q     <= yr400_d;
			underflow_q <= underflow_d;
			if (op == OP_LOAD) begin
				sday_q  <= second_day;
				smon_q  <= second_month;
				syear_q <= second_year;
			end
		end
	end

	always_comb begin
		status.underflow = underflow_q;
		status.prep_done = (yr400_q < CYCLE_Y);
		if (year_q != syear_q) begin
			status.earlier = (year_q < syear_q);
		end else if (mon_q != smon_q) begin
			status.earlier = (mon_q < smon_q);
		end else begin
			status.earlier = (day_q < sday_q);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/calendar_day_difference_core.sv =====
// ----------------------------------------------------------------------------
// calendar_day_difference_core
// Signed Gregorian day difference by stepping the first date back day by day.
// ----------------------------------------------------------------------------
//
//   channel | dir | beat payload
//   --------+-----+-------------------------------------------------------
//   req     | in  | first/second day, month, year; include_end_day
//   res     | out | day_difference (23-bit signed)
//
// One beat is loaded, its year is reduced mod 400 by repeated subtraction of
// 400, the step loop then steps the first date back one day at a time until it
// finishes, and the result is posted; the run time grows with the span, as set
// by the single-day decrement of the date unit.
// arst_n clears the sequencer, the working date, the step counter and the
// result valid.
// The next request beat is taken while a result still waits in the output
// register; a finished item holds in RUN only while that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_day_difference_core #(
	parameter int YEAR_BITS = cdd_pkg::YEAR_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cdd_req_if.sink    req,
	cdd_res_if.source  res
);
	import cdd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_RUN
	} state_t;

	state_t                   state_q;
	logic [DIFF_W-1:0]        cnt_q;
	logic                     incl_q;
	logic                     res_valid_q;
	logic signed [DIFF_W-1:0] res_data_q;

	cdd_op_t     op;
	cdd_status_t st;
	logic        accept;
	logic        finish;
	logic        out_free;
	logic        post;
	logic [DIFF_W-1:0] diff;

	assign req.ready          = (state_q == S_IDLE);
	assign accept             = req.valid && req.ready;
	assign res.valid          = res_valid_q;
	assign res.day_difference = res_data_q;

	// Stop on year underflow, on the saturation limit, or once strictly earlier.
	assign finish   = st.underflow || (cnt_q == STEP_LIMIT) || st.earlier;
	assign out_free = !res_valid_q || res.ready;
	assign post     = (state_q == S_RUN) && finish && out_free;
	assign diff     = (cnt_q == STEP_LIMIT) ? SAT_CODE :
		(DIFF_W'(!incl_q) - cnt_q);

	always_comb begin
		op = OP_HOLD;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op = OP_LOAD;
				end
			end
			S_PREP: begin
				if (!st.prep_done) begin
					op = OP_PREP;
				end
			end
			S_RUN: begin
				if (!finish) begin
					op = OP_STEP;
				end
			end
			default: begin
				op = OP_HOLD;
			end
		endcase
	end

	cdd_date_unit #(
		.YEAR_BITS (YEAR_BITS)
	) u_date (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.first_day    (req.first_day),
		.first_month  (req.first_month),
		.first_year   (req.first_year),
		.second_day   (req.second_day),
		.second_month (req.second_month),
		.second_year  (req.second_year),
		.status       (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			incl_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_data_q  <= '0;
		end else begin
			// Post a finished result, else drop the held one once the sink takes it.
			if (post) begin
				res_valid_q <= 1'b1;
				res_data_q  <= $signed(diff);
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						incl_q  <= req.include_end_day;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (st.prep_done) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (!finish) begin
						cnt_q <= cnt_q + DIFF_W'(1);
					end else if (out_free) begin
						// Result posted above; free the request side.
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= STEP_LIMIT)
		else $error("step count passed the saturation limit");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_PREP) && (cnt_q == '0))
		else $error("accepted beat did not start a fresh count");

	a_done_posts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && ($past(state_q) == S_RUN) |-> res_valid_q)
		else $error("finished item left no result");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_data_q <= $signed(DIFF_W'(1))))
		else $error("result above one");

endmodule

`default_nettype wire
